### hw/rtl/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
package bba_pkg;

    localparam int DEF_NUM_BLOCKS    = 8192;
    localparam int DEF_MAP_WORD_BITS = 32;
    localparam int IDX_W             = 13;   // block index field width
    localparam int WADDR_W           = 16;   // map word address carried between modules
    localparam int SUM_GROUP         = 16;   // summary bits per search group (power of two)

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic             func;
        logic [IDX_W-1:0] block_index;
    } bba_req_t;

    typedef struct packed {
        logic [IDX_W-1:0] granted_index;
        logic             status;
    } bba_rsp_t;

    // summary / hand update from the controller
    typedef struct packed {
        logic               sum_we;
        logic               nonempty;
        logic               hand_we;
        logic [WADDR_W-1:0] word;
    } bba_srch_upd_t;

    // next-fit search result
    typedef struct packed {
        logic               found;
        logic [WADDR_W-1:0] word;
    } bba_srch_res_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_UPDATE
    } bba_state_t;

endpackage

### hw/rtl/bba_chan_if.sv
// Valid/ready channel interface carrying one word per handshake.
interface bba_chan_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/bba_map_mem.sv
// Free bitmap memory: one write port, one registered read port, fill pass after reset.
module bba_map_mem #(
    parameter int NUM_BLOCKS    = bba_pkg::DEF_NUM_BLOCKS,
    parameter int MAP_WORD_BITS = bba_pkg::DEF_MAP_WORD_BITS,
    localparam int MAP_WORDS    = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS,
    localparam int AW           = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr,
    output logic [MAP_WORD_BITS-1:0] rd_data,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic [MAP_WORD_BITS-1:0] wr_data,
    output logic                     init_done
);
    localparam int LAST_BITS = NUM_BLOCKS - (MAP_WORDS - 1) * MAP_WORD_BITS;
    localparam logic [MAP_WORD_BITS-1:0] LAST_MASK =
        {MAP_WORD_BITS{1'b1}} >> (MAP_WORD_BITS - LAST_BITS);

    logic [MAP_WORD_BITS-1:0] mem [MAP_WORDS];
    logic [MAP_WORD_BITS-1:0] rd_data_reg;
    logic                     busy_reg, busy_next;
    logic [AW-1:0]            ptr_reg, ptr_next;
    logic                     we;
    logic [AW-1:0]            waddr;
    logic [MAP_WORD_BITS-1:0] wdata;

    always_comb
    begin
        busy_next = busy_reg;
        ptr_next  = ptr_reg;
        if (busy_reg)
        begin
            ptr_next = ptr_reg + AW'(1);
            if (ptr_reg == AW'(MAP_WORDS - 1))
            begin
                busy_next = 1'b0;
            end
        end
        we    = busy_reg ? 1'b1 : wr_en;
        waddr = busy_reg ? ptr_reg : wr_addr;
        if (busy_reg)
        begin
            wdata = (ptr_reg == AW'(MAP_WORDS - 1)) ? LAST_MASK : {MAP_WORD_BITS{1'b1}};
        end
        else
        begin
            wdata = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            ptr_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            ptr_reg  <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data   = rd_data_reg;
    assign init_done = !busy_reg;
endmodule

### hw/rtl/bba_hand_search.sv
// Word-nonempty summary, search hand and two-stage next-fit search.
module bba_hand_search #(
    parameter int NUM_BLOCKS    = bba_pkg::DEF_NUM_BLOCKS,
    parameter int MAP_WORD_BITS = bba_pkg::DEF_MAP_WORD_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bba_pkg::bba_srch_upd_t upd,
    output bba_pkg::bba_srch_res_t res
);
    localparam int MAP_WORDS = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int GRP       = bba_pkg::SUM_GROUP;
    localparam int GB        = $clog2(GRP);
    localparam int NG        = (MAP_WORDS + GRP - 1) / GRP;
    localparam int NGB       = (NG > 1) ? $clog2(NG) : 1;
    localparam int PW        = NGB + GB;
    localparam int PADW      = NG * GRP;

    logic [MAP_WORDS-1:0] nonempty_reg;
    logic [AW-1:0]        hand_reg;

    // stage 1: per-group lowest set word, over the whole group and masked to words at or past the hand
    logic [NG-1:0]  m_any_reg, m_any_next;
    logic [NG-1:0]  a_any_reg, a_any_next;
    logic [GB-1:0]  m_off_reg [NG];
    logic [GB-1:0]  m_off_next [NG];
    logic [GB-1:0]  a_off_reg [NG];
    logic [GB-1:0]  a_off_next [NG];

    logic [PADW-1:0] sum_pad;
    logic [PW-1:0]   hand_pad;
    logic [NGB-1:0]  hand_grp;
    logic [GB-1:0]   hand_off;
    logic [NGB-1:0]  sel_grp;
    logic [GB-1:0]   sel_off;
    logic [AW-1:0]   word_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonempty_reg <= '1;
            hand_reg     <= '0;
        end
        else
        begin
            if (upd.sum_we)
            begin
                nonempty_reg[upd.word[AW-1:0]] <= upd.nonempty;
            end
            if (upd.hand_we)
            begin
                hand_reg <= upd.word[AW-1:0];
            end
        end
    end

    always_comb
    begin
        logic [GRP-1:0] grp_bits;
        logic [GRP-1:0] m_bits;
        sum_pad  = PADW'(nonempty_reg);
        hand_pad = PW'(hand_reg);
        hand_grp = hand_pad[PW-1:GB];
        hand_off = hand_pad[GB-1:0];
        for (int g = 0; g < NG; g++)
        begin
            grp_bits = sum_pad[g*GRP +: GRP];
            if (NGB'(g) > hand_grp)
            begin
                m_bits = grp_bits;
            end
            else if (NGB'(g) == hand_grp)
            begin
                m_bits = grp_bits & ({GRP{1'b1}} << hand_off);
            end
            else
            begin
                m_bits = '0;
            end
            m_any_next[g] = |m_bits;
            a_any_next[g] = |grp_bits;
            m_off_next[g] = '0;
            a_off_next[g] = '0;
            for (int i = GRP - 1; i >= 0; i--)
            begin
                if (m_bits[i])
                begin
                    m_off_next[g] = GB'(i);
                end
                if (grp_bits[i])
                begin
                    a_off_next[g] = GB'(i);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_any_reg <= m_any_next;
        a_any_reg <= a_any_next;
        m_off_reg <= m_off_next;
        a_off_reg <= a_off_next;
    end

    // stage 2: first set word at or past the hand, else wrap to the first set word overall
    always_comb
    begin
        sel_grp = '0;
        sel_off = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (a_any_reg[g])
            begin
                sel_grp = NGB'(g);
                sel_off = a_off_reg[g];
            end
        end
        if (|m_any_reg)
        begin
            for (int g = NG - 1; g >= 0; g--)
            begin
                if (m_any_reg[g])
                begin
                    sel_grp = NGB'(g);
                    sel_off = m_off_reg[g];
                end
            end
        end
        word_sel            = AW'({sel_grp, sel_off});
        res.found           = |a_any_reg;
        res.word            = '0;
        res.word[AW-1:0]    = word_sel;
    end
endmodule

### hw/rtl/bitmap_block_allocator_core.sv
// Top level of the bitmap block allocator: controller, result register, submodules.
//
//  channel  dir  word fields                         accepted when
//  -------  ---  ----------------------------------  ---------------------
//  req      in   func, block_index                   req.valid & req.ready
//  rsp      out  granted_index, status               rsp.valid & rsp.ready
//
// Allocate steps through accept, group scan, pick + map read and write back;
// free through accept + map read and write back. rsp.valid is registered at
// write-back; one word is in flight, as req.ready is high only in idle.
// After reset a fill pass writes all MAP_WORDS map words (256 at the
// defaults) and then leaves init; req.ready is low until then.
// A result held in the output register parks the next word in write-back.
module bitmap_block_allocator_core #(
    parameter int NUM_BLOCKS    = bba_pkg::DEF_NUM_BLOCKS,
    parameter int MAP_WORD_BITS = bba_pkg::DEF_MAP_WORD_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    bba_chan_if.sink    req,
    bba_chan_if.source  rsp
);
    localparam int MAP_WORDS = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WB        = $clog2(MAP_WORD_BITS);   // word width is a power of two
    localparam int IDXW      = bba_pkg::IDX_W;

    bba_pkg::bba_state_t state_reg, state_next;

    logic            func_reg, func_next;
    logic            in_range_reg, in_range_next;
    logic            found_reg, found_next;
    logic [AW-1:0]   word_reg, word_next;
    logic [WB-1:0]   bit_reg, bit_next;

    logic            out_valid_reg, out_valid_next;
    bba_pkg::bba_rsp_t out_word_reg, out_word_next;

    // map memory port
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic [MAP_WORD_BITS-1:0] rd_data;
    logic                     wr_en;
    logic [MAP_WORD_BITS-1:0] wr_data;
    logic                     init_done;

    bba_pkg::bba_srch_upd_t srch_upd;
    bba_pkg::bba_srch_res_t srch_res;

    logic                     accept;
    logic                     advance;
    logic [WB-1:0]            low_bit;
    logic [MAP_WORD_BITS-1:0] new_word;

    bba_map_mem #(
        .NUM_BLOCKS    (NUM_BLOCKS),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (word_reg),
        .wr_data   (wr_data),
        .init_done (init_done)
    );

    bba_hand_search #(
        .NUM_BLOCKS    (NUM_BLOCKS),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_search (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (srch_upd),
        .res   (srch_res)
    );

    assign req.ready   = (state_reg == bba_pkg::ST_IDLE);
    assign accept      = req.valid && req.ready;
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_word_reg;

    // lowest free block in the word just read
    always_comb
    begin
        low_bit = '0;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--)
        begin
            if (rd_data[i])
            begin
                low_bit = WB'(i);
            end
        end
    end

    always_comb
    begin
        if (func_reg == bba_pkg::FUNC_FREE)
        begin
            new_word = rd_data | (MAP_WORD_BITS'(1) << bit_reg);
        end
        else
        begin
            new_word = rd_data & ~(MAP_WORD_BITS'(1) << low_bit);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        in_range_next  = in_range_reg;
        found_next     = found_reg;
        word_next      = word_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        rd_en          = 1'b0;
        rd_addr        = word_reg;
        wr_en          = 1'b0;
        wr_data        = new_word;
        srch_upd       = '0;
        advance        = 1'b0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            bba_pkg::ST_INIT:
            begin
                if (init_done)
                begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end
            bba_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    func_next     = req.payload.func;
                    in_range_next = 32'(req.payload.block_index) < 32'(NUM_BLOCKS);
                    word_next     = AW'(req.payload.block_index >> WB);
                    bit_next      = req.payload.block_index[WB-1:0];
                    if (req.payload.func == bba_pkg::FUNC_FREE)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = word_next;
                        state_next = bba_pkg::ST_UPDATE;
                    end
                    else
                    begin
                        state_next = bba_pkg::ST_SCAN;
                    end
                end
            end
            bba_pkg::ST_SCAN:
            begin
                // group encoders load this cycle
                state_next = bba_pkg::ST_PICK;
            end
            bba_pkg::ST_PICK:
            begin
                found_next = srch_res.found;
                word_next  = srch_res.word[AW-1:0];
                rd_en      = srch_res.found;
                rd_addr    = srch_res.word[AW-1:0];
                state_next = bba_pkg::ST_UPDATE;
            end
            bba_pkg::ST_UPDATE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    advance        = 1'b1;
                    out_valid_next = 1'b1;
                    out_word_next  = '0;
                    state_next     = bba_pkg::ST_IDLE;
                    if (func_reg == bba_pkg::FUNC_FREE)
                    begin
                        out_word_next.status = bba_pkg::STATUS_OK;
                        wr_en                = in_range_reg;
                    end
                    else if (found_reg)
                    begin
                        out_word_next.status        = bba_pkg::STATUS_OK;
                        out_word_next.granted_index = IDXW'({word_reg, low_bit});
                        wr_en                       = 1'b1;
                        srch_upd.hand_we            = 1'b1;
                    end
                    else
                    begin
                        out_word_next.status = bba_pkg::STATUS_FAIL;
                    end
                    srch_upd.sum_we         = wr_en;
                    srch_upd.nonempty       = |new_word;
                    srch_upd.word           = '0;
                    srch_upd.word[AW-1:0]   = word_reg;
                end
            end
            default:
            begin
                state_next = bba_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bba_pkg::ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        in_range_reg <= in_range_next;
        found_reg    <= found_next;
        word_reg     <= word_next;
        bit_reg      <= bit_next;
        out_word_reg <= out_word_next;
    end

    // A word the summary marks nonempty must read back nonzero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bba_pkg::ST_UPDATE && func_reg == bba_pkg::FUNC_ALLOC && found_reg)
        |-> (rd_data != '0))
    else $error("allocate picked an empty map word");

    // No map write until the fill pass is finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        !init_done |-> !wr_en)
    else $error("map write during fill pass");

    // Only one word in flight: accept is followed by a busy cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
    else $error("second word accepted while busy");

    // A finished update always leaves a result in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
    else $error("result lost at write-back");

    // A successful allocate reports success.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && func_reg == bba_pkg::FUNC_ALLOC && found_reg)
        |=> (out_word_reg.status == bba_pkg::STATUS_OK))
    else $error("allocate status wrong");
endmodule

### sim/bba_alloc_checker.sv
// Channel monitor for the block allocator: tracks the pool and checks every result word.
module bba_alloc_checker (
    input  logic clk,
    input  logic rst_n,
    bba_chan_if  req,
    bba_chan_if  rsp,
    output int   errors,
    output int   pending,
    output int   grants,
    output int   exhausted,
    output int   releases
);

    localparam int NUM_BLOCKS = bba_pkg::DEF_NUM_BLOCKS;
    localparam int WORD_BITS  = bba_pkg::DEF_MAP_WORD_BITS;
    localparam int MAP_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;

    logic [WORD_BITS-1:0] pool_map [MAP_WORDS];   // one = block free
    int unsigned          scan_start;             // next-fit starting word
    bba_pkg::bba_rsp_t    owed_q [$];             // results still to come, oldest first
    bba_pkg::bba_req_t    req_word;
    bba_pkg::bba_rsp_t    rsp_word;

    assign req_word = req.payload;
    assign rsp_word = rsp.payload;

    // Applies one request to the pool and returns the result word it owes.
    function automatic bba_pkg::bba_rsp_t apply_request(bba_pkg::bba_req_t r);
        bba_pkg::bba_rsp_t res;
        int unsigned       w;
        int unsigned       b;
        bit                hit;
        res = '0;
        if (r.func == bba_pkg::FUNC_FREE) begin
            // double free just sets the bit again
            if (r.block_index < NUM_BLOCKS)
                pool_map[r.block_index / WORD_BITS][r.block_index % WORD_BITS] = 1'b1;
            return res;
        end
        w   = (scan_start < MAP_WORDS) ? scan_start : 0;
        hit = 1'b0;
        for (int n = 0; n < MAP_WORDS && !hit; n++) begin
            if (pool_map[w] != '0)
                hit = 1'b1;
            else
                w = (w + 1) % MAP_WORDS;
        end
        if (!hit) begin
            // empty pool: map and start word stay as they are
            res.status = bba_pkg::STATUS_FAIL;
            return res;
        end
        b = 0;
        while (!pool_map[w][b])
            b++;
        pool_map[w][b]    = 1'b0;
        scan_start        = w;
        res.granted_index = bba_pkg::IDX_W'(w * WORD_BITS + b);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bba_pkg::bba_rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAP_WORDS; i++)
            begin
                if (NUM_BLOCKS - i * WORD_BITS >= WORD_BITS)
                    pool_map[i] = '1;
                else
                    pool_map[i] = (WORD_BITS'(1) << (NUM_BLOCKS - i * WORD_BITS)) - 1'b1;
            end
            scan_start = 0;
            owed_q.delete();
            errors    = 0;
            grants    = 0;
            exhausted = 0;
            releases  = 0;
            pending  <= 0;
        end
        else
        begin
            // result first: a word accepted now never answers a request accepted now
            if (rsp.valid && rsp.ready)
            begin
                if (owed_q.size() == 0)
                begin
                    $error("unexpected result word: granted_index %0d status %0d",
                           rsp_word.granted_index, rsp_word.status);
                    errors++;
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (rsp_word.granted_index !== want.granted_index)
                    begin
                        $error("granted_index: expected %0d, got %0d",
                               want.granted_index, rsp_word.granted_index);
                        errors++;
                    end
                    if (rsp_word.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_word.status);
                        errors++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                want = apply_request(req_word);
                owed_q.push_back(want);
                if (req_word.func == bba_pkg::FUNC_FREE)
                    releases++;
                else if (want.status == bba_pkg::STATUS_FAIL)
                    exhausted++;
                else
                    grants++;
            end
            pending <= owed_q.size();
        end
    end

endmodule

### sim/tb.sv
// Top of the allocator testbench: clock, reset, request and result traffic, verdict.
module tb;

    // Random part size; with the directed words in front, about 1050 words in all.
    localparam int RANDOM_WORDS = 1034;
    // Long result-side hold-off: starts once this many result words have gone by.
    localparam int HOLD_AT      = 40;
    localparam int HOLD_CYCLES  = 400;
    // Drain wait after pending reaches zero; this covers any stray word after the last one.
    localparam int DRAIN_CYCLES = 12;
    // Budget: the longest gap, an allocate and the longest stall per word, for
    // ~1130 words, plus map init and the hold.
    localparam int CYCLE_LIMIT  = 60000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bit   tx_calm   = 1'b0;   // sender runs back to back while set
    bit   rx_calm   = 1'b0;   // receiver takes every word at once while set
    int   rsp_words = 0;
    int   cycles    = 0;

    int   errors;
    int   pending;
    int   grants;
    int   exhausted;
    int   releases;

    bba_chan_if #(.payload_t(bba_pkg::bba_req_t)) req_ch ();
    bba_chan_if #(.payload_t(bba_pkg::bba_rsp_t)) rsp_ch ();

    bitmap_block_allocator_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    bba_alloc_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .errors    (errors),
        .pending   (pending),
        .grants    (grants),
        .exhausted (exhausted),
        .releases  (releases)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Watchdog: a hung handshake or a missing result ends up here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offers one request word and returns at the edge where it is taken.
    // valid is only dropped when a gap follows, so a back-to-back word never
    // sees a low and a high scheduled in the same step.
    task automatic send_word(input logic f, input logic [bba_pkg::IDX_W-1:0] idx);
        int                gap;
        bba_pkg::bba_req_t w;
        if ($urandom_range(0, 63) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 4);
        w.func        = f;
        w.block_index = idx;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= w;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    function automatic logic [bba_pkg::IDX_W-1:0] any_block();
        return bba_pkg::IDX_W'($urandom_range(0, bba_pkg::DEF_NUM_BLOCKS - 1));
    endfunction

    // Result side: random stall before each word, calm stretches with none,
    // and one long hold-off so the core backs up and drops req.ready.
    initial
    begin
        int stall;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                rx_calm = !rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 4);
            if (rsp_words == HOLD_AT)
                stall = HOLD_CYCLES;
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            rsp_words++;
        end
    end

    // Request side and verdict.
    initial
    begin
        int run;
        int first;
        int done;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        // req.ready stays low through the map init pass; send_word just waits.

        // Directed: block_index is a don't-care on allocate, so drive its extremes there.
        send_word(bba_pkg::FUNC_ALLOC, bba_pkg::IDX_W'(bba_pkg::DEF_NUM_BLOCKS - 1)); // -> 0
        send_word(bba_pkg::FUNC_ALLOC, '0);                           // -> block 1
        send_word(bba_pkg::FUNC_ALLOC, 13'h1555);                     // -> block 2
        send_word(bba_pkg::FUNC_FREE,  13'd1);
        send_word(bba_pkg::FUNC_FREE,  13'd1);                        // double free
        send_word(bba_pkg::FUNC_FREE,  bba_pkg::IDX_W'(bba_pkg::DEF_NUM_BLOCKS - 1));
        send_word(bba_pkg::FUNC_ALLOC, 13'h0AAA);                     // block 1 again
        send_word(bba_pkg::FUNC_FREE,  13'd0);
        send_word(bba_pkg::FUNC_ALLOC, '1);                           // block 0 comes back
        send_word(bba_pkg::FUNC_FREE,  13'h0AAA);
        send_word(bba_pkg::FUNC_FREE,  13'h1555);
        send_word(bba_pkg::FUNC_FREE,  13'd31);                       // top bit, first word
        send_word(bba_pkg::FUNC_FREE,  13'd32);                       // first bit, next word
        send_word(bba_pkg::FUNC_ALLOC, 13'd32);
        send_word(bba_pkg::FUNC_FREE,  '0);
        send_word(bba_pkg::FUNC_ALLOC, 13'h1FFF);

        // Random traffic on a mostly free pool. Mostly single allocates and
        // frees anywhere (repeats included); now and then a run of consecutive
        // frees, wrapping at the top block, is followed by a burst of allocates
        // that walks the start word forward through the map.
        done = 0;
        while (done < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                run   = $urandom_range(1, 40);
                first = $urandom_range(0, bba_pkg::DEF_NUM_BLOCKS - 1);
                for (int k = 0; k < run; k++)
                    send_word(bba_pkg::FUNC_FREE, bba_pkg::IDX_W'(first + k));
                repeat (run + 2) send_word(bba_pkg::FUNC_ALLOC, any_block());
                done += 2 * run + 2;
            end
            else
            begin
                if ($urandom_range(0, 99) < 55)
                    send_word(bba_pkg::FUNC_ALLOC, any_block());
                else
                    send_word(bba_pkg::FUNC_FREE, any_block());
                done++;
            end
        end
        req_ch.valid <= 1'b0;

        // pending is registered in the checker, so it lags the queue it reports.
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d grants, %0d allocates refused on an empty pool, %0d frees",
                 grants, exhausted, releases);
        $display("Directed reuse and double frees, then random churn with free/claim bursts");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
hw/rtl/bba_pkg.sv
hw/rtl/bba_chan_if.sv
hw/rtl/bba_map_mem.sv
hw/rtl/bba_hand_search.sv
hw/rtl/bitmap_block_allocator_core.sv
sim/bba_alloc_checker.sv
sim/tb.sv
